// ===== sv/pjhs_pkg.sv =====
// ----------------------------------------------------------------------------
// pjhs_pkg: shared definitions for the PNG / JPEG header sniffer
// Parser phase codes, verdict codes, the parser state record and helpers.
// ----------------------------------------------------------------------------
package pjhs_pkg;

  localparam int SIZE_BITS = 24;
  localparam int PHASE_BITS = 4;
  localparam int KIND_BITS = 2;

  // Parser phases.
  localparam logic [PHASE_BITS-1:0] PH_START = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_PNG   = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_SOI   = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_FF    = 4'd3;
  localparam logic [PHASE_BITS-1:0] PH_MARK  = 4'd4;
  localparam logic [PHASE_BITS-1:0] PH_LENHI = 4'd5;
  localparam logic [PHASE_BITS-1:0] PH_LENLO = 4'd6;
  localparam logic [PHASE_BITS-1:0] PH_SKIP  = 4'd7;
  localparam logic [PHASE_BITS-1:0] PH_SOF   = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_DONE  = 4'd9;

  // Verdicts.
  localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_PNG  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_JPEG = 2'd2;

  // Byte values and limits.
  localparam logic [7:0] PNG_FIRST   = 8'd137;
  localparam logic [7:0] JPEG_FILL   = 8'hff;
  localparam logic [7:0] JPEG_SOI    = 8'hd8;
  localparam logic [7:0] JPEG_SOS    = 8'hda;
  localparam logic [7:0] JPEG_EOI    = 8'hd9;
  localparam logic [7:0] JPEG_SOF0   = 8'hc0;
  localparam logic [7:0] JPEG_SOF2   = 8'hc2;
  localparam logic [SIZE_BITS-1:0] MIN_SIZE     = SIZE_BITS'(24);
  localparam logic [SIZE_BITS-1:0] PNG_MIN_SIZE = SIZE_BITS'(33);
  localparam logic [SIZE_BITS-1:0] MAX_SIZE_RESET = {SIZE_BITS{1'b1}};
  localparam logic [31:0] DIM_MAX  = 32'd4096;
  localparam logic [25:0] AREA_MAX = 26'd8388608;

  typedef struct packed {
    logic [SIZE_BITS-1:0]  pos;
    logic [PHASE_BITS-1:0] phase;
    logic [15:0]           seg;
    logic [7:0]            marker;
    logic [31:0]           width;
    logic [31:0]           height;
    logic                  done;
  } pjhs_state_t;

  function automatic pjhs_state_t clear_state();
    pjhs_state_t s;
    s.pos    = '0;
    s.phase  = PH_START;
    s.seg    = '0;
    s.marker = '0;
    s.width  = '0;
    s.height = '0;
    s.done   = 1'b0;
    return s;
  endfunction

  // Expected byte of the PNG signature, IHDR length and IHDR tag, by position.
  function automatic logic [7:0] png_expect(input logic [3:0] idx);
    logic [7:0] v;
    case (idx)
      4'd0:    v = 8'd137;
      4'd1:    v = 8'd80;
      4'd2:    v = 8'd78;
      4'd3:    v = 8'd71;
      4'd4:    v = 8'd13;
      4'd5:    v = 8'd10;
      4'd6:    v = 8'd26;
      4'd7:    v = 8'd10;
      4'd11:   v = 8'd13;
      4'd12:   v = 8'h49;
      4'd13:   v = 8'h48;
      4'd14:   v = 8'h44;
      4'd15:   v = 8'h52;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic dims_ok(input logic [31:0] w, input logic [31:0] h);
    logic [25:0] area;
    area = 26'(w[12:0]) * 26'(h[12:0]);
    return (w != 32'd0) && (h != 32'd0) && (w <= DIM_MAX) && (h <= DIM_MAX)
        && (area <= AREA_MAX);
  endfunction

endpackage

// ===== sv/pjhs_step.sv =====
// ----------------------------------------------------------------------------
// pjhs_step: per-byte parser update
// Works out the next parser state and any verdict for one byte.
// ----------------------------------------------------------------------------
module pjhs_step (
  input  pjhs_pkg::pjhs_state_t            st,
  input  logic [7:0]                       byte_value,
  input  logic [pjhs_pkg::SIZE_BITS-1:0]   image_size,
  input  logic                             is_last,
  input  logic [pjhs_pkg::SIZE_BITS-1:0]   max_size,
  output pjhs_pkg::pjhs_state_t            st_next,
  output logic                             emit,
  output logic [pjhs_pkg::KIND_BITS-1:0]   kind
);

  localparam int LW = pjhs_pkg::SIZE_BITS + 1;

  pjhs_pkg::pjhs_state_t           s;
  logic                            dec;
  logic [pjhs_pkg::KIND_BITS-1:0]  dk;
  logic [pjhs_pkg::SIZE_BITS-1:0]  p;
  logic [LW-1:0]                   size_w;
  logic [15:0]                     len;
  logic [LW-1:0]                   seg_end;
  logic [31:0]                     w_new;

  function automatic logic [pjhs_pkg::SIZE_BITS-1:0] SIZE_BITS_T(input int v);
    return pjhs_pkg::SIZE_BITS'(v);
  endfunction

  assign p       = st.pos;
  assign size_w  = {1'b0, image_size};
  assign len     = {st.seg[7:0], byte_value};
  // End of the segment: length counted from the high length byte.
  assign seg_end = LW'(len) + LW'(p) - LW'(1);
  assign w_new   = {st.width[23:0], byte_value};

  always_comb begin
    s   = st;
    dec = 1'b0;
    dk  = pjhs_pkg::KIND_NONE;
    if (!st.done) begin
      unique case (st.phase)
        pjhs_pkg::PH_START: begin
          if (image_size < pjhs_pkg::MIN_SIZE || image_size > max_size) begin
            dec = 1'b1;
          end else if (byte_value == pjhs_pkg::PNG_FIRST) begin
            if (image_size < pjhs_pkg::PNG_MIN_SIZE) dec = 1'b1;
            else s.phase = pjhs_pkg::PH_PNG;
          end else if (byte_value == pjhs_pkg::JPEG_FILL) begin
            s.phase = pjhs_pkg::PH_SOI;
          end else begin
            dec = 1'b1;
          end
        end
        pjhs_pkg::PH_PNG: begin
          if (p < SIZE_BITS_T(16)) begin
            if (byte_value != pjhs_pkg::png_expect(p[3:0])) dec = 1'b1;
          end else if (p < SIZE_BITS_T(20)) begin
            s.width = {st.width[23:0], byte_value};
          end else if (p < SIZE_BITS_T(24)) begin
            s.height = {st.height[23:0], byte_value};
            if (p == SIZE_BITS_T(23)) begin
              dec = 1'b1;
              if (pjhs_pkg::dims_ok(st.width, s.height)) dk = pjhs_pkg::KIND_PNG;
            end
          end else begin
            dec = 1'b1;
          end
        end
        pjhs_pkg::PH_SOI: begin
          if (byte_value != pjhs_pkg::JPEG_SOI) dec = 1'b1;
          else s.phase = pjhs_pkg::PH_FF;
        end
        pjhs_pkg::PH_FF: begin
          if ((LW'(p) + LW'(4)) > size_w || byte_value != pjhs_pkg::JPEG_FILL) begin
            dec = 1'b1;
          end else begin
            s.phase = pjhs_pkg::PH_MARK;
          end
        end
        pjhs_pkg::PH_MARK: begin
          if (p >= image_size) begin
            dec = 1'b1;
          end else if (byte_value != pjhs_pkg::JPEG_FILL) begin
            s.marker = byte_value;
            if (byte_value == pjhs_pkg::JPEG_SOS || byte_value == pjhs_pkg::JPEG_EOI) begin
              dec = 1'b1;
            end else if ((LW'(p) + LW'(3)) > size_w) begin
              dec = 1'b1;
            end else begin
              s.phase = pjhs_pkg::PH_LENHI;
            end
          end
        end
        pjhs_pkg::PH_LENHI: begin
          s.seg   = {8'd0, byte_value};
          s.phase = pjhs_pkg::PH_LENLO;
        end
        pjhs_pkg::PH_LENLO: begin
          if (p == '0 || len < 16'd2 || seg_end > size_w) begin
            dec = 1'b1;
          end else if (st.marker == pjhs_pkg::JPEG_SOF0
                       || st.marker == pjhs_pkg::JPEG_SOF2) begin
            if (len < 16'd8) begin
              dec = 1'b1;
            end else begin
              s.seg    = '0;
              s.width  = '0;
              s.height = '0;
              s.phase  = pjhs_pkg::PH_SOF;
            end
          end else begin
            s.seg   = len - 16'd2;
            s.phase = (len == 16'd2) ? pjhs_pkg::PH_FF : pjhs_pkg::PH_SKIP;
          end
        end
        pjhs_pkg::PH_SKIP: begin
          s.seg = st.seg - 16'd1;
          if (st.seg == 16'd1) s.phase = pjhs_pkg::PH_FF;
        end
        pjhs_pkg::PH_SOF: begin
          // Precision byte first, then height and width, high byte first.
          if (st.seg == 16'd1 || st.seg == 16'd2) begin
            s.height = {st.height[23:0], byte_value};
          end else if (st.seg == 16'd3 || st.seg == 16'd4) begin
            s.width = w_new;
          end
          if (st.seg >= 16'd4) begin
            dec = 1'b1;
            if (pjhs_pkg::dims_ok(s.width, st.height)) dk = pjhs_pkg::KIND_JPEG;
          end else begin
            s.seg = st.seg + 16'd1;
          end
        end
        default: begin
          dec = 1'b1;
        end
      endcase
    end
    if (dec) begin
      s.done  = 1'b1;
      s.phase = pjhs_pkg::PH_DONE;
    end

    emit = dec;
    kind = dk;
    if (is_last) begin
      // An undecided image gets its verdict on the final byte.
      if (!st.done) emit = 1'b1;
      st_next = pjhs_pkg::clear_state();
    end else begin
      st_next = s;
      if (st.pos != {pjhs_pkg::SIZE_BITS{1'b1}}) st_next.pos = st.pos + 1'b1;
    end
  end

endmodule

// ===== sv/png_jpeg_header_sniffer_unit.sv =====
// ----------------------------------------------------------------------------
// png_jpeg_header_sniffer_unit: image type sniffer for PNG and JPEG headers
// Streams an image file one byte per beat and returns one verdict per image.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the result side keeps up.
// The byte that decides an image passes the input register, during which the
// parse logic updates the parser state and works out the verdict, and the
// verdict then goes to the result register. Each image yields exactly one
// verdict beat (0 none, 1 PNG, 2 JPEG), either on the byte that settles it or
// on the byte flagged is_last; bytes after a verdict are consumed silently,
// and the byte after is_last starts a new image. While a verdict waits in the
// result register with out_ready low, the parse stage holds and the input
// register fills, so in_ready drops after at most one more beat.
// The max_size register (reset to all ones) is written through the cfg
// channel, which is always ready; write it only while no image is in flight.
// ----------------------------------------------------------------------------
module png_jpeg_header_sniffer_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          byte_value,
  input  logic [pjhs_pkg::SIZE_BITS-1:0]      image_size,
  input  logic                                is_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pjhs_pkg::KIND_BITS-1:0]      mime_kind,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pjhs_pkg::SIZE_BITS-1:0]      cfg_data
);

  // Configuration register.
  logic [pjhs_pkg::SIZE_BITS-1:0] max_size;

  // Input register.
  logic                           s1_valid;
  logic [7:0]                     s1_byte;
  logic [pjhs_pkg::SIZE_BITS-1:0] s1_size;
  logic                           s1_last;

  // Parser state and the step logic around it.
  pjhs_pkg::pjhs_state_t          state;
  pjhs_pkg::pjhs_state_t          state_next;
  logic                           emit;
  logic [pjhs_pkg::KIND_BITS-1:0] kind;

  // The parse stage fires when it holds a byte and the result register is
  // free or being emptied this cycle.
  logic s1_go;

  assign s1_go     = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign cfg_ready = 1'b1;

  pjhs_step u_step (
    .st         (state),
    .byte_value (s1_byte),
    .image_size (s1_size),
    .is_last    (s1_last),
    .max_size   (max_size),
    .st_next    (state_next),
    .emit       (emit),
    .kind       (kind)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_size <= pjhs_pkg::MAX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= byte_value;
      s1_size <= image_size;
      s1_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pjhs_pkg::clear_state();
    end else if (s1_go) begin
      state <= state_next;
    end
  end

  // Result register: a verdict beat is loaded only when the stage fires.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      mime_kind <= kind;
    end
  end

endmodule

// ===== sim/tb_png_jpeg_header_sniffer_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_png_jpeg_header_sniffer_unit: self-checking bench for the image sniffer
// Streams whole images (PNG, JPEG, broken and random) one byte per beat, checks
// verdicts against an in-step parser predictor, or hand-typed directed ones.
// ----------------------------------------------------------------------------
module tb_png_jpeg_header_sniffer_unit;
  import pjhs_pkg::*;

  // Directed rows either leave the verdict to the predictor, state that the
  // byte gives no verdict, or carry the verdict typed in by hand.
  typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_KIND} row_check_t;

  typedef struct {
    logic [7:0]           value;
    logic [SIZE_BITS-1:0] declared;
    logic                 last;
    row_check_t           check;
    logic [KIND_BITS-1:0] want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 22;
  localparam int PHASE_QUOTA   = 350;
  localparam int HOLD_CYCLES   = 300;

  // PNG signature, IHDR length and IHDR tag by byte position.
  localparam logic [7:0] PNG_HEAD [16] = '{
    8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10,
    8'd0, 8'd0, 8'd0, 8'd13, 8'h49, 8'h48, 8'h44, 8'h52
  };

  // The directed rows open with short images that are rejected outright or end early,
  // then a broken SOI, an EOI before any frame header, and finally a
  // progressive JPEG whose 4096 x 2048 frame sits exactly on the area limit.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 24'd0,       1'b1, CHK_KIND,  KIND_NONE},  // size zero
    '{8'hff, 24'hffffff,  1'b1, CHK_KIND,  KIND_NONE},  // ends before SOI
    '{8'd137, 24'd32,     1'b1, CHK_KIND,  KIND_NONE},  // PNG too short
    '{8'h00, 24'd24,      1'b0, CHK_KIND,  KIND_NONE},  // unknown first byte
    '{8'hff, 24'd24,      1'b1, CHK_QUIET, KIND_NONE},  // ignored after verdict
    '{8'hff, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h00, 24'd24,      1'b1, CHK_KIND,  KIND_NONE},  // broken SOI
    '{8'hff, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hd8, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hff, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hd9, 24'd24,      1'b1, CHK_KIND,  KIND_NONE},  // EOI before frame
    '{8'hff, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hd8, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hff, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'hc2, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h00, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h08, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h08, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h08, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h00, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h10, 24'd24,      1'b0, CHK_MODEL, KIND_NONE},
    '{8'h00, 24'd24,      1'b1, CHK_KIND,  KIND_JPEG}   // area exactly at limit
  };

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [7:0]           byte_value;
  logic [SIZE_BITS-1:0] image_size;
  logic                 is_last;
  logic                 out_valid;
  logic                 out_ready;
  logic [KIND_BITS-1:0] mime_kind;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [SIZE_BITS-1:0] cfg_data;

  png_jpeg_header_sniffer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .image_size (image_size),
    .is_last    (is_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mime_kind  (mime_kind),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Verdicts still owed by the block, oldest first.
  logic [KIND_BITS-1:0] pending_kinds [$];
  int                   failures;
  int                   verdicts_seen;
  int                   sent_bytes;
  int                   idle_pct;
  int                   stall_pct;

  // Image under construction for the random part.
  logic [7:0]           img_bytes [$];
  logic [SIZE_BITS-1:0] img_size;

  // Queues grow at the tail: owed verdicts and image bytes.
  function automatic void owe_kind(input logic [KIND_BITS-1:0] k);
    pending_kinds.insert(pending_kinds.size(), k);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    img_bytes.insert(img_bytes.size(), b);
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and of the size limit.
  // ---------------------------------------------------------------------------
  logic [SIZE_BITS-1:0]  cfg_max_size;
  logic [SIZE_BITS-1:0]  at_pos;
  logic [PHASE_BITS-1:0] at_phase;
  logic [15:0]           seg_left;
  logic [7:0]            seg_marker;
  logic [31:0]           img_w;
  logic [31:0]           img_h;
  logic                  settled;

  function automatic void forget_image();
    at_pos     = '0;
    at_phase   = PH_START;
    seg_left   = '0;
    seg_marker = '0;
    img_w      = '0;
    img_h      = '0;
    settled    = 1'b0;
  endfunction

  // Both sides at most 4096 and nonzero, and the pixel count within the limit.
  function automatic bit frame_fits(input logic [31:0] w, input logic [31:0] h);
    longint unsigned area;
    area = longint'(w) * longint'(h);
    return w != 0 && h != 0 && w <= DIM_MAX && h <= DIM_MAX && area <= AREA_MAX;
  endfunction

  // Advances the parser by one byte. Returns 1 when the byte settles the image.
  function automatic bit parse_byte(input logic [7:0] b, input logic [SIZE_BITS-1:0] sz,
                                    output logic [KIND_BITS-1:0] kind);
    int unsigned p;
    int unsigned s;
    int unsigned len;
    bit          decided;
    p       = 32'(at_pos);
    s       = 32'(sz);
    decided = 1'b0;
    kind    = KIND_NONE;
    case (at_phase)
      PH_START: begin
        // The range test only ever looks at the size on the first byte.
        if (sz < MIN_SIZE || sz > cfg_max_size) decided = 1'b1;
        else if (b == PNG_FIRST) begin
          if (sz < PNG_MIN_SIZE) decided = 1'b1;
          else at_phase = PH_PNG;
        end else if (b == JPEG_FILL) at_phase = PH_SOI;
        else decided = 1'b1;
      end
      PH_PNG: begin
        if (p < 16) begin
          if (b != PNG_HEAD[p]) decided = 1'b1;
        end else if (p < 20) begin
          img_w = {img_w[23:0], b};
        end else if (p < 24) begin
          img_h = {img_h[23:0], b};
          if (p == 23) begin
            decided = 1'b1;
            kind    = frame_fits(img_w, img_h) ? KIND_PNG : KIND_NONE;
          end
        end else begin
          decided = 1'b1;
        end
      end
      PH_SOI: begin
        if (b != JPEG_SOI) decided = 1'b1;
        else at_phase = PH_FF;
      end
      PH_FF: begin
        // A marker needs room for itself and its two length bytes.
        if (p + 4 > s || b != JPEG_FILL) decided = 1'b1;
        else at_phase = PH_MARK;
      end
      PH_MARK: begin
        if (p >= s) decided = 1'b1;
        else if (b != JPEG_FILL) begin
          seg_marker = b;
          if (b == JPEG_SOS || b == JPEG_EOI) decided = 1'b1;
          else if (p + 3 > s) decided = 1'b1;
          else at_phase = PH_LENHI;
        end
      end
      PH_LENHI: begin
        seg_left = {8'd0, b};
        at_phase = PH_LENLO;
      end
      PH_LENLO: begin
        len = 32'({seg_left[7:0], b});
        if (p == 0 || len < 2 || len + (p - 1) > s) decided = 1'b1;
        else if (seg_marker == JPEG_SOF0 || seg_marker == JPEG_SOF2) begin
          if (len < 8) decided = 1'b1;
          else begin
            seg_left = '0;
            img_w    = '0;
            img_h    = '0;
            at_phase = PH_SOF;
          end
        end else begin
          seg_left = 16'(len - 2);
          at_phase = (len == 2) ? PH_FF : PH_SKIP;
        end
      end
      PH_SKIP: begin
        seg_left = seg_left - 16'd1;
        if (seg_left == 16'd0) at_phase = PH_FF;
      end
      PH_SOF: begin
        // Frame header: precision, then height and width, big endian.
        if (seg_left == 16'd1 || seg_left == 16'd2) img_h = {img_h[23:0], b};
        else if (seg_left == 16'd3 || seg_left == 16'd4) img_w = {img_w[23:0], b};
        if (seg_left >= 16'd4) begin
          decided = 1'b1;
          kind    = frame_fits(img_w, img_h) ? KIND_JPEG : KIND_NONE;
        end else begin
          seg_left = seg_left + 16'd1;
        end
      end
      default: decided = 1'b1;
    endcase
    if (decided) begin
      settled  = 1'b1;
      at_phase = PH_DONE;
    end
    return decided;
  endfunction

  // Full per-beat prediction, including the end-of-image rule: the is_last
  // byte forces a "none" verdict if nothing was settled, then clears the parser.
  function automatic bit predict_verdict(input logic [7:0] b,
                                         input logic [SIZE_BITS-1:0] sz,
                                         input logic last,
                                         output logic [KIND_BITS-1:0] kind);
    bit got;
    got  = 1'b0;
    kind = KIND_NONE;
    if (!settled) got = parse_byte(b, sz, kind);
    if (last) begin
      if (!settled) begin
        kind = KIND_NONE;
        got  = 1'b1;
      end
      forget_image();
    end else if (at_pos != '1) begin
      at_pos = at_pos + 1'b1;
    end
    return got;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and run limit.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus one long hold-off. The hold starts once a
  // dozen verdicts have come back, and lasts long enough that the sender keeps
  // offering bytes into a full pipeline and in_ready has to drop.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && verdicts_seen >= 12) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic log_failure(input string what, input logic [KIND_BITS-1:0] want,
                             input logic [KIND_BITS-1:0] got);
    failures++;
    if (failures <= 10)
      $display("[%0t] %s: expected mime_kind %0d, got %0d", $time, what, want, got);
  endtask

  // Every verdict beat is matched against the oldest owed verdict.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      verdicts_seen++;
      if (pending_kinds.size() == 0) log_failure("verdict with none owed", 2'bxx, mime_kind);
      else if (mime_kind !== pending_kinds[0]) begin
        log_failure("verdict mismatch", pending_kinds[0], mime_kind);
        void'(pending_kinds.pop_front());
      end else begin
        void'(pending_kinds.pop_front());
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Offers one byte beat and records what it should cause once accepted.
  // Called and returning at a falling edge; valid stays high between beats
  // unless an idle cycle is drawn.
  task automatic offer_byte(input logic [7:0] b, input logic [SIZE_BITS-1:0] sz,
                            input logic last, input row_check_t check,
                            input logic [KIND_BITS-1:0] want);
    logic [KIND_BITS-1:0] kind;
    bit                   got;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    byte_value <= b;
    image_size <= sz;
    is_last    <= last;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    got = predict_verdict(b, sz, last, kind);
    case (check)
      CHK_MODEL: if (got) owe_kind(kind);
      CHK_KIND:  owe_kind(want);
      default:   ;
    endcase
    @(negedge clk);
  endtask

  // The limit may only change between images with nothing in flight, so the
  // task drains the owed verdicts, idles so that the pipeline empties, then
  // writes. The new idling mix takes effect right after the write.
  task automatic write_max_size(input logic [SIZE_BITS-1:0] limit, input int sender_idle,
                                input int receiver_stall);
    in_valid <= 1'b0;
    while (pending_kinds.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (!cfg_ready);
    cfg_max_size = limit;
    idle_pct     = sender_idle;
    stall_pct    = receiver_stall;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_dims(output logic [31:0] w, output logic [31:0] h);
    case ($urandom_range(0, 7))
      0: begin w = $urandom_range(1, 640);  h = $urandom_range(1, 480);  end
      1: begin w = 32'd4096;                h = 32'd2048;                end
      2: begin w = 32'd2049;                h = 32'd4096;                end
      3: begin w = 32'd0;                   h = $urandom_range(1, 100);  end
      4: begin w = $urandom_range(1, 100);  h = 32'd4097;                end
      5: begin w = 32'd4096;                h = 32'd4096;                end
      6: begin w = $urandom;                h = $urandom;                end
      default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 2048); end
    endcase
  endtask

  // Builds one image: mostly well-formed PNG and JPEG headers with random
  // content, some with a damaged byte, plus random noise. The declared size is
  // usually honest, sometimes wild, sometimes clipped to the current limit,
  // and now and then the stream ends early.
  task automatic build_image();
    logic [31:0] w;
    logic [31:0] h;
    int unsigned pick;
    int unsigned floor_size;
    int unsigned seg_len;
    int unsigned r;
    int          len;
    img_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      for (int i = 0; i < 16; i++) add_byte(PNG_HEAD[i]);
      pick_dims(w, h);
      for (int i = 3; i >= 0; i--) add_byte(w[8*i +: 8]);
      for (int i = 3; i >= 0; i--) add_byte(h[8*i +: 8]);
    end else if (pick < 80) begin
      add_byte(JPEG_FILL);
      add_byte(JPEG_SOI);
      repeat ($urandom_range(0, 2)) begin
        // A skipped segment, sometimes with fill bytes before its marker and
        // now and then with a length that is too small or far too large.
        add_byte(JPEG_FILL);
        repeat ($urandom_range(0, 2)) add_byte(JPEG_FILL);
        case ($urandom_range(0, 4))
          0:       add_byte(8'he0);
          1:       add_byte(8'he1);
          2:       add_byte(8'hdb);
          3:       add_byte(8'hc4);
          default: add_byte(8'hfe);
        endcase
        r = $urandom_range(0, 19);
        if (r == 0) seg_len = $urandom_range(0, 1);
        else if (r == 1) seg_len = $urandom_range(0, 16'hffff);
        else seg_len = $urandom_range(2, 6);
        add_byte(seg_len[15:8]);
        add_byte(seg_len[7:0]);
        if (seg_len >= 2 && seg_len <= 6)
          repeat (seg_len - 2) add_byte(8'($urandom));
      end
      add_byte(JPEG_FILL);
      if ($urandom_range(0, 6) != 0) begin
        add_byte($urandom_range(0, 1) ? JPEG_SOF0 : JPEG_SOF2);
        seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 17);
        add_byte(8'd0);
        add_byte(seg_len[7:0]);
        add_byte(8'd8);
        pick_dims(w, h);
        add_byte(h[15:8]);
        add_byte(h[7:0]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
      end else begin
        // Scan or end of image before any frame header.
        add_byte($urandom_range(0, 1) ? JPEG_SOS : JPEG_EOI);
      end
    end else begin
      repeat ($urandom_range(1, 30)) add_byte(8'($urandom));
      r = $urandom_range(0, 2);
      if (r == 0) img_bytes[0] = PNG_FIRST;
      else if (r == 1) img_bytes[0] = JPEG_FILL;
    end

    if (pick < 80 && $urandom_range(0, 4) == 0)
      img_bytes[$urandom_range(0, img_bytes.size() - 1)] = 8'($urandom);

    floor_size = (pick < 40) ? 33 : 24;
    case ($urandom_range(0, 9))
      0:       img_size = SIZE_BITS'($urandom);
      1:       img_size = SIZE_BITS'($urandom_range(0, 40));
      default: begin
        img_size = (img_bytes.size() > floor_size) ? SIZE_BITS'(img_bytes.size())
                                                   : SIZE_BITS'(floor_size);
        img_size = SIZE_BITS'(img_size + $urandom_range(0, 8));
      end
    endcase
    if ($urandom_range(0, 3) != 0 && img_size > cfg_max_size) img_size = cfg_max_size;

    if (img_size >= img_bytes.size() && img_size <= 64) len = int'(img_size);
    else len = img_bytes.size() + $urandom_range(0, 4);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
    while (img_bytes.size() < len) add_byte(8'($urandom));
    while (img_bytes.size() > len) void'(img_bytes.pop_back());
  endtask

  // Sends the built image; a few beats carry a different declared size.
  task automatic stream_image();
    logic [SIZE_BITS-1:0] sz;
    foreach (img_bytes[i]) begin
      sz = (i > 0 && $urandom_range(0, 99) < 3) ? SIZE_BITS'($urandom) : img_size;
      offer_byte(img_bytes[i], sz, i == img_bytes.size() - 1, CHK_MODEL, KIND_NONE);
    end
  endtask

  task automatic random_images(input int quota);
    int stop_at;
    stop_at = sent_bytes + quota;
    while (sent_bytes < stop_at) begin
      build_image();
      stream_image();
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    byte_value    = '0;
    image_size    = '0;
    is_last       = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    failures      = 0;
    verdicts_seen = 0;
    sent_bytes    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    cfg_max_size  = MAX_SIZE_RESET;
    forget_image();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Full-range limit, no idling on either side: directed rows, then images.
    write_max_size(24'hffffff, 0, 0);
    foreach (directed_rows[i])
      offer_byte(directed_rows[i].value, directed_rows[i].declared, directed_rows[i].last,
                 directed_rows[i].check, directed_rows[i].want);
    random_images(PHASE_QUOTA);

    // Smallest limit, which rejects every PNG; the sender is mostly idle.
    write_max_size(MIN_SIZE, 88, 0);
    random_images(PHASE_QUOTA);

    // A tight limit at or just above the PNG minimum; the receiver mostly stalls.
    write_max_size(SIZE_BITS'($urandom_range(33, 64)), 0, 88);
    random_images(PHASE_QUOTA);

    // A random wide limit with light idling on both sides.
    write_max_size(SIZE_BITS'($urandom_range(65, 24'hffffff)), 25, 25);
    random_images(PHASE_QUOTA);

    in_valid <= 1'b0;
    while (pending_kinds.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
